/* design/csvfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_pkg
// shared types and constants of the csv field splitter
// ----------------------------------------------------------------------------
package csvfs_pkg;

	localparam int MAX_FIELDS = 16;
	localparam int CNT_W      = $clog2(MAX_FIELDS + 1);
	localparam int NUM_W      = 4;

	localparam logic [CNT_W-1:0] MAX_FIELDS_RESET = CNT_W'(12);

	localparam logic [7:0] QUOTE_CHAR = 8'h22;
	localparam logic [7:0] COMMA_CHAR = 8'h2C;

	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_PLAIN  = 3'd1,
		MODE_QUOTED = 3'd2,
		MODE_QEND   = 3'd3,
		MODE_SKIP   = 3'd4,
		MODE_FULL   = 3'd5
	} mode_t;

	typedef struct packed {
		logic             content_valid;
		logic [7:0]       content_byte;
		logic             field_done;
		logic [NUM_W-1:0] field_number;
		logic             line_done;
		logic [CNT_W-1:0] field_count;
	} result_t;

	typedef struct packed {
		mode_t            mode;
		logic [CNT_W-1:0] seen;
	} parse_state_t;

endpackage

/* design/csvfs_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_step
// one-byte parse step: next state and the optional result
// ----------------------------------------------------------------------------
module csvfs_step (
	input  logic                      kind,
	input  logic [7:0]                data_byte,
	input  logic [csvfs_pkg::CNT_W-1:0] max_fields,
	input  csvfs_pkg::parse_state_t   cur,
	output csvfs_pkg::parse_state_t   nxt,
	output logic                      res_valid,
	output csvfs_pkg::result_t        res
);

	logic [csvfs_pkg::CNT_W-1:0] limit;
	logic [csvfs_pkg::CNT_W-1:0] seen_inc;
	logic                        last;
	logic                        full_after;
	logic                        is_quote;
	logic                        is_comma;
	logic                        open;
	csvfs_pkg::mode_t            mode_eff;

	// clamp limit to 1..MAX_FIELDS
	always_comb begin
		if (max_fields == '0) begin
			limit = csvfs_pkg::CNT_W'(1);
		end else if (max_fields > csvfs_pkg::CNT_W'(csvfs_pkg::MAX_FIELDS)) begin
			limit = csvfs_pkg::CNT_W'(csvfs_pkg::MAX_FIELDS);
		end else begin
			limit = max_fields;
		end
	end

	assign seen_inc   = cur.seen + csvfs_pkg::CNT_W'(1);
	assign last       = seen_inc >= limit;
	assign full_after = seen_inc >= limit;
	assign is_quote   = data_byte == csvfs_pkg::QUOTE_CHAR;
	assign is_comma   = data_byte == csvfs_pkg::COMMA_CHAR;
	assign open       = (cur.mode == csvfs_pkg::MODE_PLAIN) ||
	                    (cur.mode == csvfs_pkg::MODE_QUOTED) ||
	                    (cur.mode == csvfs_pkg::MODE_QEND);

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		mode_eff  = cur.mode;
		if ((cur.mode == csvfs_pkg::MODE_START) && (cur.seen >= limit)) begin
			mode_eff = csvfs_pkg::MODE_FULL;
		end

		if (kind) begin
			// end of line: close any open field, report count
			res_valid          = 1'b1;
			res.line_done      = 1'b1;
			res.field_done     = open;
			res.field_number   = open ? cur.seen[csvfs_pkg::NUM_W-1:0] : '0;
			res.field_count    = open ? seen_inc : cur.seen;
			nxt.mode           = csvfs_pkg::MODE_START;
			nxt.seen           = '0;
		end else begin
			case (mode_eff)
				csvfs_pkg::MODE_START: begin
					if (is_quote) begin
						nxt.mode = csvfs_pkg::MODE_QUOTED;
					end else if (is_comma && !last) begin
						res_valid        = 1'b1;
						res.field_done   = 1'b1;
						res.field_number = cur.seen[csvfs_pkg::NUM_W-1:0];
						nxt.seen         = seen_inc;
						nxt.mode         = full_after ? csvfs_pkg::MODE_FULL
						                              : csvfs_pkg::MODE_START;
					end else begin
						res_valid         = 1'b1;
						res.content_valid = 1'b1;
						res.content_byte  = data_byte;
						res.field_number  = cur.seen[csvfs_pkg::NUM_W-1:0];
						nxt.mode          = csvfs_pkg::MODE_PLAIN;
					end
				end
				csvfs_pkg::MODE_PLAIN: begin
					res_valid        = 1'b1;
					res.field_number = cur.seen[csvfs_pkg::NUM_W-1:0];
					if (is_comma && !last) begin
						res.field_done = 1'b1;
						nxt.seen       = seen_inc;
						nxt.mode       = full_after ? csvfs_pkg::MODE_FULL
						                            : csvfs_pkg::MODE_START;
					end else begin
						res.content_valid = 1'b1;
						res.content_byte  = data_byte;
					end
				end
				csvfs_pkg::MODE_QUOTED: begin
					if (is_quote) begin
						nxt.mode = csvfs_pkg::MODE_QEND;
					end else begin
						res_valid         = 1'b1;
						res.content_valid = 1'b1;
						res.content_byte  = data_byte;
						res.field_number  = cur.seen[csvfs_pkg::NUM_W-1:0];
					end
				end
				csvfs_pkg::MODE_QEND: begin
					res_valid        = 1'b1;
					res.field_number = cur.seen[csvfs_pkg::NUM_W-1:0];
					if (is_quote) begin
						// doubled quote
						res.content_valid = 1'b1;
						res.content_byte  = data_byte;
						nxt.mode          = csvfs_pkg::MODE_QUOTED;
					end else begin
						res.field_done = 1'b1;
						nxt.seen       = seen_inc;
						if (full_after) begin
							nxt.mode = csvfs_pkg::MODE_FULL;
						end else if (is_comma) begin
							nxt.mode = csvfs_pkg::MODE_START;
						end else begin
							nxt.mode = csvfs_pkg::MODE_SKIP;
						end
					end
				end
				csvfs_pkg::MODE_SKIP: begin
					if (is_comma) begin
						nxt.mode = csvfs_pkg::MODE_START;
					end
				end
				default: begin
					nxt.mode = csvfs_pkg::MODE_FULL;
				end
			endcase
		end
	end

endmodule

/* design/csv_field_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter
// splits a stream of line bytes into comma-separated fields
// ----------------------------------------------------------------------------
// One request per line byte (tuser = 0) and one end-of-line request
// (tuser = 1). Each request yields at most one result: an unescaped content
// byte, a field-end mark, or for end of line a line-done result (tlast) with
// the field count. Quoted fields drop their enclosing quotes and fold a
// doubled quote into one; bytes after a closing quote up to the next comma
// are dropped. The field at the last allowed index takes the rest of the line
// if it is unquoted; once the limit is met further bytes give no result.
// Throughput is one request per clock unless the result side stalls: the
// input register and the result register are split by a single parse step,
// and the mode and field counter feed back within the same cycle. A request
// is registered, then its result. cfg_data (max_fields, reset 12, 0 acts as
// 1, above 16 acts as 16) may be written only while no request is in flight.
module csv_field_splitter (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,       // [4:0] max_fields
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] kind
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] content_byte, [11:8] field_number,
	                                    // [16:12] field_count, rest zero
	output logic [1:0]  m_axis_tuser,   // [0] content_valid, [1] field_done
	output logic        m_axis_tlast    // line_done
);

	// configuration register
	logic [csvfs_pkg::CNT_W-1:0] max_fields_q;

	// input register
	logic       s1_valid;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// parse state
	csvfs_pkg::parse_state_t state_q;
	csvfs_pkg::parse_state_t state_nxt;

	// result register
	logic               out_valid_q;
	csvfs_pkg::result_t out_q;

	logic               res_valid;
	csvfs_pkg::result_t res;
	logic               out_free;
	logic               s1_adv;

	// result slot free when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_adv        = s1_valid && out_free;
	assign s_axis_tready = !s1_valid || out_free;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= csvfs_pkg::MAX_FIELDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_fields_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	csvfs_step u_step (
		.kind       (kind_s1),
		.data_byte  (byte_s1),
		.max_fields (max_fields_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	// parse state advances only when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= csvfs_pkg::MODE_START;
			state_q.seen <= '0;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.field_count, out_q.field_number, out_q.content_byte};
	assign m_axis_tuser  = {out_q.field_done, out_q.content_valid};
	assign m_axis_tlast  = out_q.line_done;

	// field counter never passes the hard limit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seen <= csvfs_pkg::CNT_W'(csvfs_pkg::MAX_FIELDS))
		else $error("field counter above limit");

	// an end-of-line item leaves a fresh line behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && kind_s1) |=>
		(state_q.seen == '0) && (state_q.mode == csvfs_pkg::MODE_START))
		else $error("line state not cleared after end of line");

	// a result is content or a field end, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("content and field end on one result");

	// count only on line results, and within range
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[16:12] == 5'd0))
		else $error("field count outside line result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tdata[16:12] <= 5'(csvfs_pkg::MAX_FIELDS)))
		else $error("field count above limit");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the csv field splitter
// ----------------------------------------------------------------------------
// Lines of bytes go in as a stream, both well-formed csv (quoted fields with
// doubled quotes, junk after closing quotes, trailing commas, unterminated
// quotes) and noise. A scoreboard runs its own parser on every accepted
// request and checks each result in order. The field limit is rewritten
// between phases (0, 1, 2, 3, 12, 16, 31 and random values), sometimes in
// the middle of a line. Both stream sides idle at random, and once the
// result side holds off long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module tb;

	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 190;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AT      = 300;
	localparam int SETTLE       = 8;

	// one input byte or end-of-line marker
	typedef struct {
		bit         is_eol;
		logic [7:0] b;
	} line_item_t;

	// predicts the token stream of the splitter and checks results against it
	class splitter_scoreboard;
		csvfs_pkg::result_t          token_q[$];
		csvfs_pkg::mode_t            mode;
		logic [csvfs_pkg::CNT_W-1:0] seen;
		logic [4:0]                  max_fields;
		int                          errors;

		function new();
			mode = csvfs_pkg::MODE_START;
			seen = '0;
			max_fields = 5'(csvfs_pkg::MAX_FIELDS_RESET);
			errors = 0;
		endfunction

		function void set_limit(logic [4:0] v);
			max_fields = v;
		endfunction

		function int pending();
			return token_q.size();
		endfunction

		function void content(output csvfs_pkg::result_t r, input logic [7:0] b);
			r = '0;
			r.content_valid = 1'b1;
			r.content_byte = b;
			r.field_number = seen[csvfs_pkg::NUM_W-1:0];
		endfunction

		// ends the current field; full once the limit is met
		function void close_field(output csvfs_pkg::result_t r,
			input csvfs_pkg::mode_t next_mode, input int lim);
			r = '0;
			r.field_done = 1'b1;
			r.field_number = seen[csvfs_pkg::NUM_W-1:0];
			seen = seen + 1'b1;
			mode = (int'(seen) >= lim) ? csvfs_pkg::MODE_FULL : next_mode;
		endfunction

		function void predict_token(bit is_eol, logic [7:0] b);
			csvfs_pkg::result_t r;
			int                 lim;
			bit                 last_field;
			bit                 open;
			bit                 emit;
			lim = int'(max_fields);
			if (lim < 1) lim = 1;
			if (lim > csvfs_pkg::MAX_FIELDS) lim = csvfs_pkg::MAX_FIELDS;
			last_field = (int'(seen) + 1) >= lim;
			r = '0;
			emit = 1'b1;
			if (is_eol) begin
				open = (mode == csvfs_pkg::MODE_PLAIN) ||
				       (mode == csvfs_pkg::MODE_QUOTED) ||
				       (mode == csvfs_pkg::MODE_QEND);
				if (open) begin
					r.field_done = 1'b1;
					r.field_number = seen[csvfs_pkg::NUM_W-1:0];
					seen = seen + 1'b1;
				end
				r.line_done = 1'b1;
				r.field_count = seen;
				mode = csvfs_pkg::MODE_START;
				seen = '0;
			end else begin
				if (mode == csvfs_pkg::MODE_START && int'(seen) >= lim)
					mode = csvfs_pkg::MODE_FULL;
				case (mode)
					csvfs_pkg::MODE_START: begin
						if (b == csvfs_pkg::QUOTE_CHAR) begin
							mode = csvfs_pkg::MODE_QUOTED;
							emit = 1'b0;
						end else if (b == csvfs_pkg::COMMA_CHAR && !last_field) begin
							close_field(r, csvfs_pkg::MODE_START, lim);
						end else begin
							mode = csvfs_pkg::MODE_PLAIN;
							content(r, b);
						end
					end
					csvfs_pkg::MODE_PLAIN: begin
						if (b == csvfs_pkg::COMMA_CHAR && !last_field)
							close_field(r, csvfs_pkg::MODE_START, lim);
						else
							content(r, b);
					end
					csvfs_pkg::MODE_QUOTED: begin
						if (b == csvfs_pkg::QUOTE_CHAR) begin
							mode = csvfs_pkg::MODE_QEND;
							emit = 1'b0;
						end else begin
							content(r, b);
						end
					end
					csvfs_pkg::MODE_QEND: begin
						if (b == csvfs_pkg::QUOTE_CHAR) begin
							mode = csvfs_pkg::MODE_QUOTED;
							content(r, b);
						end else if (b == csvfs_pkg::COMMA_CHAR) begin
							close_field(r, csvfs_pkg::MODE_START, lim);
						end else begin
							close_field(r, csvfs_pkg::MODE_SKIP, lim);
						end
					end
					csvfs_pkg::MODE_SKIP: begin
						if (b == csvfs_pkg::COMMA_CHAR) mode = csvfs_pkg::MODE_START;
						emit = 1'b0;
					end
					default: begin
						mode = csvfs_pkg::MODE_FULL;
						emit = 1'b0;
					end
				endcase
			end
			if (emit) token_q.insert(token_q.size(), r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_token(logic [23:0] d, logic [1:0] u, logic l);
			csvfs_pkg::result_t e;
			if (token_q.size() == 0) begin
				report($sformatf("result with nothing expected (tdata %h)", d));
				return;
			end
			e = token_q.pop_front();
			if (u[0] !== e.content_valid)
				report($sformatf("content_valid %b, want %b", u[0], e.content_valid));
			if (d[7:0] !== e.content_byte)
				report($sformatf("content_byte %h, want %h", d[7:0], e.content_byte));
			if (u[1] !== e.field_done)
				report($sformatf("field_done %b, want %b", u[1], e.field_done));
			if (d[11:8] !== e.field_number)
				report($sformatf("field_number %0d, want %0d", d[11:8], e.field_number));
			if (l !== e.line_done)
				report($sformatf("line_done %b, want %b", l, e.line_done));
			if (d[16:12] !== e.field_count)
				report($sformatf("field_count %0d, want %0d", d[16:12], e.field_count));
			if (d[23:17] !== 7'd0)
				report($sformatf("tdata padding %h not zero", d[23:17]));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	splitter_scoreboard sb = new();

	line_item_t line_q[$];
	int         tx_run = 0;
	int         rx_run = 0;
	int         tx_gap = 0;       // gap owed before the next request
	bit         tx_hot = 1'b0;    // tvalid left high after the last accept
	int         items_sent = 0;
	int         results_taken = 0;
	logic [4:0] cur_limit = 5'(csvfs_pkg::MAX_FIELDS_RESET);

	csv_field_splitter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// idle cycles before the next handshake; now and then a run with no gaps
	function automatic int draw_gap(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic int eff_limit(logic [4:0] v);
		if (v < 1) return 1;
		if (v > csvfs_pkg::MAX_FIELDS) return csvfs_pkg::MAX_FIELDS;
		return int'(v);
	endfunction

	function void add_byte(logic [7:0] b);
		line_item_t it;
		it.is_eol = 1'b0;
		it.b = b;
		line_q.insert(line_q.size(), it);
	endfunction

	// end-of-line request, data byte is don't-care so random
	function void add_eol();
		line_item_t it;
		it.is_eol = 1'b1;
		it.b = 8'($urandom_range(0, 255));
		line_q.insert(line_q.size(), it);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == csvfs_pkg::QUOTE_CHAR || b == csvfs_pkg::COMMA_CHAR);
		return b;
	endfunction

	// well-formed line with random content; truncated lines leave a field open
	function automatic void build_line(int nfields, bit truncate);
		int len;
		int r;
		logic [7:0] b;
		for (int f = 0; f < nfields; f++) begin
			if (f > 0) add_byte(csvfs_pkg::COMMA_CHAR);
			if ($urandom_range(0, 1) == 1) begin
				add_byte(csvfs_pkg::QUOTE_CHAR);
				len = $urandom_range(0, 4);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 7);
					if (r == 0) begin
						add_byte(csvfs_pkg::QUOTE_CHAR);
						add_byte(csvfs_pkg::QUOTE_CHAR);
					end else if (r == 1) begin
						add_byte(csvfs_pkg::COMMA_CHAR);
					end else begin
						do b = 8'($urandom_range(0, 255));
						while (b == csvfs_pkg::QUOTE_CHAR);
						add_byte(b);
					end
				end
				// unterminated quote only on the last field
				if (!(f == nfields - 1 && $urandom_range(0, 7) == 0)) begin
					add_byte(csvfs_pkg::QUOTE_CHAR);
					if ($urandom_range(0, 5) == 0) begin
						len = $urandom_range(1, 3);
						for (int i = 0; i < len; i++) add_byte(plain_byte());
					end
				end
			end else begin
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0) add_byte(csvfs_pkg::QUOTE_CHAR);
					else add_byte(plain_byte());
				end
			end
		end
		if ($urandom_range(0, 5) == 0) add_byte(csvfs_pkg::COMMA_CHAR);
		if (!truncate) add_eol();
	endfunction

	// heavy on quotes and commas, no structure
	function automatic void build_noise();
		int len;
		int r;
		len = $urandom_range(0, 12);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 2);
			if (r == 0) add_byte(csvfs_pkg::QUOTE_CHAR);
			else if (r == 1) add_byte(csvfs_pkg::COMMA_CHAR);
			else add_byte(8'($urandom_range(0, 255)));
		end
		add_eol();
	endfunction

	// called at a rising edge; leaves tvalid high when the next gap is zero
	task send_item(bit is_eol, logic [7:0] b);
		if (!tx_hot && tx_gap > 0) repeat (tx_gap) @(posedge clk);
		s_axis_tdata  <= b;
		s_axis_tuser  <= is_eol;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk);
		while (!s_axis_tready);
		sb.predict_token(is_eol, b);
		items_sent++;
		tx_gap = draw_gap(tx_run);
		if (tx_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			tx_hot = 1'b0;
		end else begin
			tx_hot = 1'b1;
		end
	endtask

	task send_line();
		line_item_t it;
		while (line_q.size() > 0) begin
			it = line_q.pop_front();
			send_item(it.is_eol, it.b);
		end
	endtask

	task pause_sender();
		if (tx_hot) s_axis_tvalid <= 1'b0;
		tx_hot = 1'b0;
	endtask

	// only while idle: every result in, then a settle wait for silent requests
	task write_limit(logic [4:0] v);
		pause_sender();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_limit(v);
		cur_limit = v;
	endtask

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int  g;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			g = draw_gap(rx_run);
			if (results_taken >= HOLD_AT && !held) begin
				g = HOLD_CYCLES;
				held = 1'b1;
			end
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk);
			while (!m_axis_tvalid);
			sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			results_taken++;
		end
	end

	// stops the run after too long without any handshake
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int         nf;
		int         phase_start;
		logic [4:0] limits[8];
		limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd0, 5'd0, 5'd12};
		limits[5] = 5'($urandom_range(1, 16));
		limits[6] = 5'($urandom_range(17, 30));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset limit: quoted field with doubled quote, junk after
		// the closing quote, empty field, extreme bytes, trailing comma
		add_byte(csvfs_pkg::QUOTE_CHAR); add_byte(8'h61);
		add_byte(csvfs_pkg::QUOTE_CHAR); add_byte(csvfs_pkg::QUOTE_CHAR);
		add_byte(csvfs_pkg::QUOTE_CHAR); add_byte(8'h78);
		add_byte(csvfs_pkg::COMMA_CHAR); add_byte(csvfs_pkg::COMMA_CHAR);
		add_byte(8'h00); add_byte(8'hFF); add_byte(csvfs_pkg::COMMA_CHAR); add_eol();
		// empty line, then an unterminated quoted field
		add_eol();
		add_byte(csvfs_pkg::QUOTE_CHAR); add_byte(8'h71); add_eol();
		send_line();

		// limit two: last field takes commas; quoted last field ends at quote
		write_limit(5'd2);
		add_byte(8'h61); add_byte(csvfs_pkg::COMMA_CHAR); add_byte(8'h62);
		add_byte(csvfs_pkg::COMMA_CHAR); add_eol();
		add_byte(csvfs_pkg::COMMA_CHAR); add_byte(csvfs_pkg::QUOTE_CHAR);
		add_byte(8'h7A); add_byte(csvfs_pkg::QUOTE_CHAR); add_byte(8'h6B);
		add_byte(csvfs_pkg::COMMA_CHAR); add_byte(8'h6D); add_eol();
		send_line();

		// limit one: a comma at field start is content
		write_limit(5'd1);
		add_byte(csvfs_pkg::COMMA_CHAR); add_byte(csvfs_pkg::COMMA_CHAR); add_eol();
		send_line();

		// random phases; a phase may end mid-line so the next limit lands
		// on a field in progress
		foreach (limits[p]) begin
			write_limit(limits[p]);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					build_noise();
				end else begin
					nf = $urandom_range(0, eff_limit(cur_limit) + 2);
					build_line(nf, 1'b0);
				end
				send_line();
			end
			if ($urandom_range(0, 1) == 1) begin
				build_line($urandom_range(1, 3), 1'b1);
				send_line();
			end
		end
		add_eol();
		send_line();
		pause_sender();

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
